FILE: rtl/core/lrb_pkg.sv
// Package of types and codes shared by the link reconnect backoff controller.
package lrb_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned MS_W = 31;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [2:0] MODE_TICK = 3'd0;
    localparam logic [2:0] MODE_LINK_UP = 3'd1;
    localparam logic [2:0] MODE_LINK_DOWN = 3'd2;
    localparam logic [2:0] MODE_RECONNECT = 3'd3;
    localparam logic [2:0] MODE_START_FAILED = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_RETRY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTEMPT_TIMEOUT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE = 2'd3;

    typedef struct packed {
        logic [2:0]        mode;
        logic [TIME_W-1:0] now_ms;
        logic              link_up;
        logic              have_credentials;
        logic              scan_busy;
    } lrb_item_t;

    typedef struct packed {
        logic              cmd_connect;
        logic              cmd_disconnect;
        logic              notify_up;
        logic              notify_down;
        logic              attempt_active;
        logic [TIME_W-1:0] event_epoch;
        logic [MS_W-1:0]   current_backoff_ms;
    } lrb_result_t;

    typedef struct packed {
        logic [MS_W-1:0] initial_retry_ms;
        logic [MS_W-1:0] max_retry_ms;
        logic [MS_W-1:0] attempt_timeout_ms;
        logic [MS_W-1:0] settle_ms;
    } lrb_cfg_t;

    typedef struct packed {
        logic              restart_requested;
        logic              attempting;
        logic              restart_pending;
        logic              was_up;
        logic              next_try_valid;
        logic [MS_W-1:0]   backoff_ms;
        logic [TIME_W-1:0] restart_time;
        logic [TIME_W-1:0] next_try_time;
        logic [TIME_W-1:0] attempt_start_time;
        logic [TIME_W-1:0] epoch_count;
    } lrb_state_t;

endpackage

FILE: rtl/core/lrb_chan_if.sv
// Valid/ready channel interface carrying one payload per transaction.
interface lrb_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/core/lrb_cfg_regs.sv
// Configuration register file of the link reconnect backoff controller.
module lrb_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [lrb_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [lrb_pkg::MS_W-1:0]      wr_data,
    output lrb_pkg::lrb_cfg_t             cfg
);
    import lrb_pkg::*;

    lrb_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.initial_retry_ms <= MS_W'(1000);
            cfg_reg.max_retry_ms <= MS_W'(60000);
            cfg_reg.attempt_timeout_ms <= MS_W'(15000);
            cfg_reg.settle_ms <= MS_W'(500);
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_INITIAL_RETRY: cfg_reg.initial_retry_ms <= wr_data;
                CFG_MAX_RETRY: cfg_reg.max_retry_ms <= wr_data;
                CFG_ATTEMPT_TIMEOUT: cfg_reg.attempt_timeout_ms <= wr_data;
                CFG_SETTLE: cfg_reg.settle_ms <= wr_data;
                default: cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/core/lrb_step.sv
// Next-state and result logic for one item of the reconnect controller.
module lrb_step (
    input  lrb_pkg::lrb_item_t   item,
    input  lrb_pkg::lrb_state_t  state,
    input  lrb_pkg::lrb_cfg_t    cfg,
    output lrb_pkg::lrb_state_t  state_next,
    output lrb_pkg::lrb_result_t result
);
    import lrb_pkg::*;

    function automatic logic reached(logic [TIME_W-1:0] now, logic [TIME_W-1:0] deadline);
        logic [TIME_W-1:0] diff;
        diff = now - deadline;
        return !diff[TIME_W-1];
    endfunction

    function automatic lrb_state_t schedule(lrb_state_t s, logic [TIME_W-1:0] t,
                                            logic [MS_W-1:0] cap);
        lrb_state_t        r;
        logic [TIME_W-1:0] dbl;
        r = s;
        dbl = {s.backoff_ms, 1'b0};
        if (!s.restart_pending && !(s.next_try_valid && !reached(t, s.next_try_time)))
        begin
            r.next_try_time = t + {1'b0, s.backoff_ms};
            r.next_try_valid = 1'b1;
            r.backoff_ms = (dbl < {1'b0, cap}) ? dbl[MS_W-1:0] : cap;
        end
        return r;
    endfunction

    lrb_state_t        st;
    logic              conn;
    logic              disc;
    logic              nup;
    logic              ndown;
    logic              active;
    logic [TIME_W-1:0] age;

    assign age = item.now_ms - state.attempt_start_time;

    always_comb
    begin
        st = state;
        conn = 1'b0;
        disc = 1'b0;
        nup = 1'b0;
        ndown = 1'b0;
        active = state.attempting || item.link_up;
        case (item.mode)
            MODE_TICK:
            begin
                if (st.restart_requested)
                begin
                    st.restart_requested = 1'b0;
                    st.attempting = 1'b0;
                    st.restart_pending = 1'b1;
                    st.backoff_ms = cfg.initial_retry_ms;
                    st.next_try_valid = 1'b0;
                    if (active)
                    begin
                        disc = 1'b1;
                        st.restart_time = item.now_ms + {1'b0, cfg.settle_ms};
                    end
                    else
                    begin
                        st.restart_time = item.now_ms;
                    end
                end
                if (!item.have_credentials)
                begin
                    st.attempting = 1'b0;
                    st.restart_pending = 1'b0;
                    st.next_try_valid = 1'b0;
                end
                else if (item.link_up)
                begin
                    st = st;
                end
                else if (st.restart_pending)
                begin
                    if (!item.scan_busy && reached(item.now_ms, st.restart_time))
                    begin
                        st.restart_pending = 1'b0;
                        st.attempting = 1'b1;
                        st.attempt_start_time = item.now_ms;
                        st.next_try_valid = 1'b0;
                        conn = 1'b1;
                    end
                end
                else if (st.attempting && (age >= {1'b0, cfg.attempt_timeout_ms}))
                begin
                    disc = 1'b1;
                    st.attempting = 1'b0;
                    st = schedule(st, item.now_ms, cfg.max_retry_ms);
                end
                else if (!st.attempting &&
                         (!st.next_try_valid || reached(item.now_ms, st.next_try_time)))
                begin
                    st.attempting = 1'b1;
                    st.attempt_start_time = item.now_ms;
                    st.next_try_valid = 1'b0;
                    conn = 1'b1;
                end
            end
            MODE_LINK_UP:
            begin
                st.epoch_count = state.epoch_count + TIME_W'(1);
                st.attempting = 1'b0;
                st.restart_pending = 1'b0;
                st.next_try_valid = 1'b0;
                st.backoff_ms = cfg.initial_retry_ms;
                nup = !state.was_up;
                st.was_up = 1'b1;
            end
            MODE_LINK_DOWN:
            begin
                st.epoch_count = state.epoch_count + TIME_W'(1);
                st.attempting = 1'b0;
                ndown = state.was_up;
                st.was_up = 1'b0;
                if (item.have_credentials)
                begin
                    st = schedule(st, item.now_ms, cfg.max_retry_ms);
                end
            end
            MODE_RECONNECT:
            begin
                st.restart_requested = 1'b1;
            end
            MODE_START_FAILED:
            begin
                if (state.attempting)
                begin
                    st.attempting = 1'b0;
                    st = schedule(st, state.attempt_start_time, cfg.max_retry_ms);
                end
            end
            default:
            begin
                st = state;
            end
        endcase
    end

    assign state_next = st;
    assign result.cmd_connect = conn;
    assign result.cmd_disconnect = disc;
    assign result.notify_up = nup;
    assign result.notify_down = ndown;
    assign result.attempt_active = st.attempting;
    assign result.event_epoch = st.epoch_count;
    assign result.current_backoff_ms = st.backoff_ms;

endmodule

FILE: rtl/core/link_reconnect_backoff_controller.sv
// Top level of the link reconnect backoff controller.
//
//   Channel   Direction  Payload        Transaction
//   items     in         lrb_item_t     one event or tick per transaction
//   results   out        lrb_result_t   one result per accepted item
//   cfg_*     in         31-bit data    one register write per enabled edge
//
// One item per cycle sustained while results are taken; each result passes through
// the input register and the result register around the update logic.
// Reset clears the controller state to a pending restart request and loads the
// register defaults. A stalled result holds the item in the input register, and
// the input side stays ready while the input register can move on.
module link_reconnect_backoff_controller (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [lrb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lrb_pkg::MS_W-1:0]      cfg_wr_data,
    lrb_chan_if.sink                      items,
    lrb_chan_if.source                    results
);
    import lrb_pkg::*;

    lrb_cfg_t    cfg;
    lrb_state_t  state_reg;
    lrb_state_t  state_next;
    lrb_item_t   s1_item_reg;
    logic        s1_valid_reg;
    lrb_result_t result_next;
    lrb_result_t result_reg;
    logic        out_valid_reg;
    logic        advance;

    lrb_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_wr_en),
        .wr_index (cfg_index),
        .wr_data  (cfg_wr_data),
        .cfg      (cfg)
    );

    lrb_step u_step (
        .item       (s1_item_reg),
        .state      (state_reg),
        .cfg        (cfg),
        .state_next (state_next),
        .result     (result_next)
    );

    assign advance = s1_valid_reg && (!out_valid_reg || results.ready);
    assign items.ready = !s1_valid_reg || advance;

    always_ff @(posedge clk)
    begin
        if (items.valid && items.ready)
        begin
            s1_item_reg <= items.payload;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg <= '{restart_requested: 1'b1, default: '0};
        end
        else
        begin
            if (items.ready)
            begin
                s1_valid_reg <= items.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg <= state_next;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign results.valid = out_valid_reg;
    assign results.payload = result_reg;

    a_pending_excludes_attempt: assert property (@(posedge clk) disable iff (!rst_n)
        !(state_reg.restart_pending && state_reg.attempting))
        else $error("restart pending while an attempt is active");

    a_connect_implies_active: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.cmd_connect |-> result_reg.attempt_active)
        else $error("connect command without an active attempt");

    a_single_notify: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(result_reg.notify_up && result_reg.notify_down))
        else $error("up and down notification in one result");

    a_epoch_only_on_link_events: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_item_reg.mode != MODE_LINK_UP && s1_item_reg.mode != MODE_LINK_DOWN
        |=> $stable(state_reg.epoch_count))
        else $error("event epoch changed on an item that is not a link event");

endmodule

FILE: verif/lrb_outcome_checker.sv
`timescale 1ns / 100ps
// Checker that predicts every controller result and compares it with the block's output.
module lrb_outcome_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [lrb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lrb_pkg::MS_W-1:0]      cfg_wr_data,
    input  logic                          item_valid,
    input  logic                          item_ready,
    input  lrb_pkg::lrb_item_t            item_payload,
    input  logic                          result_valid,
    input  logic                          result_ready,
    input  lrb_pkg::lrb_result_t          result_payload,
    output int unsigned                   mismatch_count,
    output int unsigned                   owed_count
);
    import lrb_pkg::*;

    lrb_state_t  ctl;
    lrb_cfg_t    regs;
    lrb_result_t owed_results[$];
    lrb_result_t want;
    lrb_result_t predicted;

    function automatic logic deadline_met(input logic [TIME_W-1:0] now_ms,
                                          input logic [TIME_W-1:0] when_ms);
        logic [TIME_W-1:0] diff;
        diff = now_ms - when_ms;
        return !diff[TIME_W-1];
    endfunction

    function automatic void plan_retry(input logic [TIME_W-1:0] from_ms);
        logic [TIME_W-1:0] doubled;
        if (ctl.restart_pending)
        begin
            return;
        end
        if (ctl.next_try_valid && !deadline_met(from_ms, ctl.next_try_time))
        begin
            return;
        end
        ctl.next_try_time = from_ms + {1'b0, ctl.backoff_ms};
        ctl.next_try_valid = 1'b1;
        doubled = {ctl.backoff_ms, 1'b0};
        if (doubled < {1'b0, regs.max_retry_ms})
        begin
            ctl.backoff_ms = doubled[MS_W-1:0];
        end
        else
        begin
            ctl.backoff_ms = regs.max_retry_ms;
        end
    endfunction

    function automatic void begin_attempt(input logic [TIME_W-1:0] now_ms);
        ctl.attempting = 1'b1;
        ctl.attempt_start_time = now_ms;
        ctl.next_try_valid = 1'b0;
    endfunction

    function automatic lrb_result_t step_controller(input lrb_item_t it);
        lrb_result_t r;
        logic        was_active;
        r = '0;
        case (it.mode)
            MODE_TICK:
            begin
                if (ctl.restart_requested)
                begin
                    was_active = ctl.attempting || it.link_up;
                    ctl.restart_requested = 1'b0;
                    ctl.attempting = 1'b0;
                    ctl.restart_pending = 1'b1;
                    ctl.backoff_ms = regs.initial_retry_ms;
                    ctl.next_try_valid = 1'b0;
                    if (was_active)
                    begin
                        r.cmd_disconnect = 1'b1;
                        ctl.restart_time = it.now_ms + {1'b0, regs.settle_ms};
                    end
                    else
                    begin
                        ctl.restart_time = it.now_ms;
                    end
                end
                if (!it.have_credentials)
                begin
                    ctl.attempting = 1'b0;
                    ctl.restart_pending = 1'b0;
                    ctl.next_try_valid = 1'b0;
                end
                else if (!it.link_up)
                begin
                    if (ctl.restart_pending)
                    begin
                        if (!it.scan_busy && deadline_met(it.now_ms, ctl.restart_time))
                        begin
                            ctl.restart_pending = 1'b0;
                            begin_attempt(it.now_ms);
                            r.cmd_connect = 1'b1;
                        end
                    end
                    else if (ctl.attempting && ((it.now_ms - ctl.attempt_start_time)
                             >= {1'b0, regs.attempt_timeout_ms}))
                    begin
                        r.cmd_disconnect = 1'b1;
                        ctl.attempting = 1'b0;
                        plan_retry(it.now_ms);
                    end
                    else if (!ctl.attempting && (!ctl.next_try_valid
                             || deadline_met(it.now_ms, ctl.next_try_time)))
                    begin
                        begin_attempt(it.now_ms);
                        r.cmd_connect = 1'b1;
                    end
                end
            end
            MODE_LINK_UP:
            begin
                ctl.epoch_count = ctl.epoch_count + 1'b1;
                ctl.attempting = 1'b0;
                ctl.restart_pending = 1'b0;
                ctl.next_try_valid = 1'b0;
                ctl.backoff_ms = regs.initial_retry_ms;
                r.notify_up = !ctl.was_up;
                ctl.was_up = 1'b1;
            end
            MODE_LINK_DOWN:
            begin
                ctl.epoch_count = ctl.epoch_count + 1'b1;
                ctl.attempting = 1'b0;
                r.notify_down = ctl.was_up;
                ctl.was_up = 1'b0;
                if (!ctl.restart_pending && it.have_credentials)
                begin
                    plan_retry(it.now_ms);
                end
            end
            MODE_RECONNECT:
            begin
                ctl.restart_requested = 1'b1;
            end
            MODE_START_FAILED:
            begin
                if (ctl.attempting)
                begin
                    ctl.attempting = 1'b0;
                    plan_retry(ctl.attempt_start_time);
                end
            end
            default:
            begin
            end
        endcase
        r.attempt_active = ctl.attempting;
        r.event_epoch = ctl.epoch_count;
        r.current_backoff_ms = ctl.backoff_ms;
        return r;
    endfunction

    task automatic check_field(input string what, input logic [TIME_W-1:0] exp_val,
                               input logic [TIME_W-1:0] act_val);
        if (act_val !== exp_val)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_val,
                     act_val);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            ctl = '0;
            ctl.restart_requested = 1'b1;
            regs.initial_retry_ms = MS_W'(1000);
            regs.max_retry_ms = MS_W'(60000);
            regs.attempt_timeout_ms = MS_W'(15000);
            regs.settle_ms = MS_W'(500);
            owed_results.delete();
            mismatch_count = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_INITIAL_RETRY:   regs.initial_retry_ms = cfg_wr_data;
                    CFG_MAX_RETRY:       regs.max_retry_ms = cfg_wr_data;
                    CFG_ATTEMPT_TIMEOUT: regs.attempt_timeout_ms = cfg_wr_data;
                    CFG_SETTLE:          regs.settle_ms = cfg_wr_data;
                    default:
                    begin
                    end
                endcase
            end
            if (item_valid && item_ready)
            begin
                predicted = step_controller(item_payload);
                owed_results = {owed_results, predicted};
            end
            if (result_valid && result_ready)
            begin
                if (owed_results.size() == 0)
                begin
                    $display("%0t: result transaction with nothing expected, %s %h",
                             $time, "expected none, actual", result_payload);
                    mismatch_count++;
                end
                else
                begin
                    want = owed_results.pop_front();
                    check_field("cmd_connect", want.cmd_connect, result_payload.cmd_connect);
                    check_field("cmd_disconnect", want.cmd_disconnect,
                                result_payload.cmd_disconnect);
                    check_field("notify_up", want.notify_up, result_payload.notify_up);
                    check_field("notify_down", want.notify_down, result_payload.notify_down);
                    check_field("attempt_active", want.attempt_active,
                                result_payload.attempt_active);
                    check_field("event_epoch", want.event_epoch, result_payload.event_epoch);
                    check_field("current_backoff_ms", want.current_backoff_ms,
                                result_payload.current_backoff_ms);
                end
            end
        end
        owed_count = owed_results.size();
    end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// Testbench top: clock, reset, stimulus for the reconnect controller and the final verdict.
module tb_top;
    import lrb_pkg::*;

    localparam int unsigned LONG_HOLD = 300;
    localparam int unsigned ITEMS_PER_PHASE = 66;
    localparam int unsigned PHASES = 6;
    localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [2:0] MODE_SPARE_LAST = 3'd7;
    localparam logic [MS_W-1:0] MS_MAX = '1;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [MS_W-1:0]      cfg_wr_data;
    logic                 hold_results = 1'b0;
    logic                 no_idle = 1'b0;
    logic [TIME_W-1:0]    clock_ms;
    logic                 link_is_up;
    longint unsigned      step_scale;
    int unsigned          mismatch_count;
    int unsigned          owed_count;

    lrb_chan_if #(.payload_t(lrb_item_t))   item_ch ();
    lrb_chan_if #(.payload_t(lrb_result_t)) result_ch ();

    link_reconnect_backoff_controller u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .items       (item_ch),
        .results     (result_ch)
    );

    lrb_outcome_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .item_valid     (item_ch.valid),
        .item_ready     (item_ch.ready),
        .item_payload   (item_ch.payload),
        .result_valid   (result_ch.valid),
        .result_ready   (result_ch.ready),
        .result_payload (result_ch.payload),
        .mismatch_count (mismatch_count),
        .owed_count     (owed_count)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #7_200_000;
        $display("FAIL");
        $finish;
    end

    function automatic int unsigned gap_len();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 80)
        begin
            return $urandom_range(1, 3);
        end
        else if (pick < 95)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic lrb_item_t mk_item(input logic [2:0] mode, input logic [TIME_W-1:0] now_ms,
                                          input logic up, input logic creds, input logic scan);
        lrb_item_t it;
        it.mode = mode;
        it.now_ms = now_ms;
        it.link_up = up;
        it.have_credentials = creds;
        it.scan_busy = scan;
        return it;
    endfunction

    function automatic lrb_item_t draw_item();
        lrb_item_t       it;
        int unsigned     pick;
        longint unsigned step;
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            step = $urandom_range(0, 3);
        end
        else if (pick < 45)
        begin
            step = longint'($urandom) % (step_scale / 4 + 1);
        end
        else if (pick < 85)
        begin
            step = longint'($urandom) % (step_scale + 1);
        end
        else if (pick < 97)
        begin
            step = longint'($urandom) % (2 * step_scale + 1);
        end
        else
        begin
            step = $urandom;
        end
        clock_ms = clock_ms + step[TIME_W-1:0];
        if ($urandom_range(0, 99) < 3)
        begin
            clock_ms = $urandom;
        end
        it.now_ms = clock_ms;
        it.link_up = ($urandom_range(0, 99) < 8) ? !link_is_up : link_is_up;
        it.have_credentials = ($urandom_range(0, 99) < 92);
        it.scan_busy = ($urandom_range(0, 99) < 20);
        pick = $urandom_range(0, 99);
        if (pick < 58)
        begin
            it.mode = MODE_TICK;
        end
        else if (pick < 66)
        begin
            it.mode = MODE_LINK_UP;
            link_is_up = 1'b1;
        end
        else if (pick < 74)
        begin
            it.mode = MODE_LINK_DOWN;
            link_is_up = 1'b0;
        end
        else if (pick < 80)
        begin
            it.mode = MODE_RECONNECT;
        end
        else if (pick < 96)
        begin
            it.mode = MODE_START_FAILED;
        end
        else
        begin
            it.mode = 3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
        end
        return it;
    endfunction

    function automatic lrb_cfg_t pick_config(input int unsigned phase);
        lrb_cfg_t c;
        case (phase)
            0:
            begin
                c.initial_retry_ms = MS_W'($urandom_range(1, 2000));
                c.max_retry_ms = MS_W'($urandom_range(1, 100000));
                c.attempt_timeout_ms = MS_W'($urandom_range(1, 20000));
                c.settle_ms = MS_W'($urandom_range(0, 1000));
            end
            1:
            begin
                c.initial_retry_ms = MS_MAX;
                c.max_retry_ms = MS_MAX;
                c.attempt_timeout_ms = MS_MAX;
                c.settle_ms = MS_MAX;
            end
            2:
            begin
                c.initial_retry_ms = MS_W'(1);
                c.max_retry_ms = MS_W'(1);
                c.attempt_timeout_ms = MS_W'(1);
                c.settle_ms = '0;
            end
            3:
            begin
                c.initial_retry_ms = MS_W'($urandom_range(5000, 60000));
                c.max_retry_ms = MS_W'($urandom_range(1, 1000));
                c.attempt_timeout_ms = MS_W'($urandom_range(100, 3000));
                c.settle_ms = MS_W'($urandom_range(0, 200));
            end
            4:
            begin
                c.initial_retry_ms = '0;
                c.max_retry_ms = MS_W'($urandom_range(1, 5000));
                c.attempt_timeout_ms = MS_W'($urandom_range(1, 4000));
                c.settle_ms = MS_W'($urandom_range(0, 300));
            end
            default:
            begin
                c.initial_retry_ms = MS_W'(1000);
                c.max_retry_ms = MS_W'(60000);
                c.attempt_timeout_ms = MS_W'(15000);
                c.settle_ms = MS_W'(500);
            end
        endcase
        return c;
    endfunction

    task automatic idle_sender(input int unsigned cycles);
        item_ch.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic send_item(input lrb_item_t it);
        item_ch.valid <= 1'b1;
        item_ch.payload <= it;
        do
            @(posedge clk);
        while (item_ch.ready !== 1'b1);
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            idle_sender(gap_len());
        end
    endtask

    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        @(negedge clk);
        while (owed_count != 0)
        begin
            @(negedge clk);
        end
        repeat (3) @(posedge clk);
    endtask

    task automatic write_config(input lrb_cfg_t c);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_INITIAL_RETRY;
        cfg_wr_data <= c.initial_retry_ms;
        @(posedge clk);
        cfg_index <= CFG_MAX_RETRY;
        cfg_wr_data <= c.max_retry_ms;
        @(posedge clk);
        cfg_index <= CFG_ATTEMPT_TIMEOUT;
        cfg_wr_data <= c.attempt_timeout_ms;
        @(posedge clk);
        cfg_index <= CFG_SETTLE;
        cfg_wr_data <= c.settle_ms;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        step_scale = (c.attempt_timeout_ms > c.max_retry_ms) ? c.attempt_timeout_ms
                                                              : c.max_retry_ms;
    endtask

    initial
    begin
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_results)
            begin
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_results = 1'b0;
            end
            else if (no_idle || $urandom_range(0, 3) != 0)
            begin
                result_ch.ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                result_ch.ready <= 1'b0;
                repeat (gap_len()) @(posedge clk);
            end
        end
    end

    initial
    begin
        lrb_cfg_t    cfg;
        lrb_item_t   it;
        int unsigned counted;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_INITIAL_RETRY;
        cfg_wr_data = '0;
        item_ch.valid = 1'b0;
        item_ch.payload = '0;
        link_is_up = 1'b0;
        step_scale = 15000;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default registers: restart on the first tick, retries, timeout and forced restart.
        send_item(mk_item(MODE_TICK, 32'd100, 1'b0, 1'b1, 1'b0));
        send_item(mk_item(MODE_START_FAILED, 32'd200, 1'b0, 1'b1, 1'b0));
        send_item(mk_item(MODE_START_FAILED, 32'd300, 1'b0, 1'b1, 1'b0));
        send_item(mk_item(MODE_TICK, 32'd600, 1'b0, 1'b1, 1'b0));
        send_item(mk_item(MODE_TICK, 32'd1100, 1'b0, 1'b1, 1'b0));
        send_item(mk_item(MODE_TICK, 32'd16100, 1'b0, 1'b1, 1'b0));
        send_item(mk_item(MODE_TICK, 32'd18100, 1'b0, 1'b1, 1'b0));
        send_item(mk_item(MODE_LINK_UP, 32'd18200, 1'b1, 1'b1, 1'b0));
        send_item(mk_item(MODE_TICK, 32'd18300, 1'b1, 1'b1, 1'b0));
        send_item(mk_item(MODE_RECONNECT, 32'd18400, 1'b1, 1'b1, 1'b0));
        send_item(mk_item(MODE_TICK, 32'd18500, 1'b1, 1'b1, 1'b0));
        send_item(mk_item(MODE_TICK, 32'd18600, 1'b0, 1'b1, 1'b1));
        send_item(mk_item(MODE_TICK, 32'd19000, 1'b0, 1'b1, 1'b0));
        send_item(mk_item(MODE_LINK_DOWN, 32'd19100, 1'b0, 1'b1, 1'b0));
        send_item(mk_item(MODE_TICK, 32'd19200, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(MODE_TICK, 32'd19300, 1'b0, 1'b1, 1'b0));
        send_item(mk_item(MODE_SPARE_FIRST, 32'd19400, 1'b1, 1'b1, 1'b1));
        send_item(mk_item(MODE_SPARE_LAST, 32'd19500, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(MODE_LINK_DOWN, 32'd19600, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(MODE_LINK_UP, 32'd19700, 1'b1, 1'b1, 1'b0));
        send_item(mk_item(MODE_LINK_UP, 32'd19800, 1'b1, 1'b1, 1'b0));
        send_item(mk_item(MODE_RECONNECT, 32'hFFFF_FFF0, 1'b1, 1'b1, 1'b0));
        send_item(mk_item(MODE_TICK, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0));
        send_item(mk_item(MODE_TICK, 32'h0000_0010, 1'b0, 1'b1, 1'b0));
        send_item(mk_item(MODE_START_FAILED, 32'h0000_0000, 1'b0, 1'b1, 1'b0));
        wait_drained();

        clock_ms = 32'h0000_0010;
        for (int unsigned phase = 0; phase < PHASES; phase++)
        begin
            cfg = pick_config(phase);
            write_config(cfg);
            link_is_up = 1'b0;
            if (phase == 1)
            begin
                hold_results = 1'b1;
            end
            counted = 0;
            while (counted < ITEMS_PER_PHASE)
            begin
                no_idle = (phase == PHASES - 1) || (phase == 1 && counted < 40);
                it = draw_item();
                send_item(it);
                if (it.mode <= MODE_START_FAILED)
                begin
                    counted++;
                end
                if (phase == 3 && counted == 30)
                begin
                    wait_drained();
                end
            end
            wait_drained();
        end

        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: link_reconnect_backoff_controller.f
rtl/core/lrb_pkg.sv
rtl/core/lrb_chan_if.sv
rtl/core/lrb_cfg_regs.sv
rtl/core/lrb_step.sv
rtl/core/link_reconnect_backoff_controller.sv
verif/lrb_outcome_checker.sv
verif/tb_top.sv
